FILE: src/tkc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tkc_pkg
// Shared types, register map and download sequence codes of the touch-key
// controller register unit.
// ----------------------------------------------------------------------------
package tkc_pkg;

  // request kinds carried in the input tuser
  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_KEY   = 2'd2,
    REQ_NOP   = 2'd3
  } req_type_e;

  // register map
  localparam logic [7:0] ADDR_LED_ONOFF = 8'h01;
  localparam logic [7:0] ADDR_LED_DIM   = 8'h02;
  localparam logic [7:0] ADDR_STATUS    = 8'h04;
  localparam logic [7:0] ADDR_HW_VER    = 8'h06;
  localparam logic [7:0] ADDR_FW_VER    = 8'h0A;
  localparam logic [7:0] ADDR_MI_VER    = 8'h0B;
  localparam logic [7:0] ADDR_DOWNLOAD  = 8'h7E;

  // fixed version bytes
  localparam logic [7:0] HW_REV_BYTE = 8'h09;
  localparam logic [7:0] FW_REV_BYTE = 8'h09;
  localparam logic [7:0] MI_REV_BYTE = 8'h00;

  // download handshake answers
  localparam logic [7:0] DL_ANS_HELLO = 8'h55;
  localparam logic [7:0] DL_ANS_ACK   = 8'h8F;
  localparam logic [7:0] DL_ANS_ERASE = 8'h82;
  localparam logic [7:0] DL_ANS_CNT   = 8'h84;
  localparam logic [7:0] DL_ANS_IMAGE = 8'h83;
  localparam logic [7:0] DL_ANS_BUSY  = 8'hFF;
  localparam logic [7:0] DL_ANS_DONE  = 8'h00;

  // download sequence steps
  localparam int unsigned DL_STEP_W = 4;
  localparam logic [DL_STEP_W-1:0] DL_HELLO  = 4'd0;
  localparam logic [DL_STEP_W-1:0] DL_ACK1   = 4'd1;
  localparam logic [DL_STEP_W-1:0] DL_ERASE  = 4'd2;
  localparam logic [DL_STEP_W-1:0] DL_CNT1   = 4'd3;
  localparam logic [DL_STEP_W-1:0] DL_CHECK1 = 4'd4;
  localparam logic [DL_STEP_W-1:0] DL_ACK2   = 4'd5;
  localparam logic [DL_STEP_W-1:0] DL_IMAGE  = 4'd6;
  localparam logic [DL_STEP_W-1:0] DL_CNT2   = 4'd7;
  localparam logic [DL_STEP_W-1:0] DL_CHECK2 = 4'd8;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_A_CODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_A_REPORT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_B_CODE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_B_REPORT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_C_CODE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_C_REPORT = 3'd5;

  localparam int unsigned KEY_W = 7;

  typedef struct packed {
    logic [KEY_W-1:0] key_a_code;
    logic [KEY_W-1:0] key_a_report;
    logic [KEY_W-1:0] key_b_code;
    logic [KEY_W-1:0] key_b_report;
    logic [KEY_W-1:0] key_c_code;
    logic [KEY_W-1:0] key_c_report;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    key_a_code:   7'd16,
    key_a_report: 7'd97,
    key_b_code:   7'd17,
    key_b_report: 7'd98,
    key_c_code:   7'd18,
    key_c_report: 7'd99
  };

  typedef struct packed {
    req_type_e   req_type;
    logic [7:0]  reg_address;
    logic [7:0]  access_offset;
    logic [7:0]  write_data;
    logic [7:0]  key_code;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_pulse;
    logic       access_error;
  } result_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] status;
  } key_match_t;

endpackage : tkc_pkg
`default_nettype wire

FILE: src/touchkey_controller_regs_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Path: an accepted input beat is held in the input register, then its result
// beat in the result register.
// Throughput: one item per cycle; the input register and result register
// advance together whenever the result register is empty or being drained.
// Reset: status, download step and count clear to zero, key registers
// return to their default codes and reports, both stages empty.
// ----------------------------------------------------------------------------
// touchkey_controller_regs_unit
// Touch-key controller register block: bus reads and writes, key events and
// the firmware-download handshake, one result beat per input beat.
// ----------------------------------------------------------------------------
module touchkey_controller_regs_unit (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // configuration write port
  input  wire logic                             cfg_we_i,
  input  wire logic [tkc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [tkc_pkg::KEY_W-1:0]        cfg_wdata_i,
  // input stream
  input  wire logic                             s_axis_tvalid,
  output      logic                             s_axis_tready,
  // [7:0] reg_address, [15:8] access_offset, [23:16] write_data,
  // [31:24] key_code
  input  wire logic [31:0]                      s_axis_tdata,
  // [1:0] req_type
  input  wire logic [1:0]                       s_axis_tuser,
  // result stream
  output      logic                             m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // [7:0] read_data, [8] irq_pulse, [9] access_error, [15:10] zero
  output      logic [15:0]                      m_axis_tdata
);

  tkc_pkg::cfg_t    cfg_q;
  tkc_pkg::item_t   in_item_q;
  logic             in_vld_q;
  tkc_pkg::result_t res_d, res_q;
  logic             out_vld_q;
  logic             advance;
  logic             s_fire;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= tkc_pkg::CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tkc_pkg::CFG_KEY_A_CODE:   cfg_q.key_a_code   <= cfg_wdata_i;
        tkc_pkg::CFG_KEY_A_REPORT: cfg_q.key_a_report <= cfg_wdata_i;
        tkc_pkg::CFG_KEY_B_CODE:   cfg_q.key_b_code   <= cfg_wdata_i;
        tkc_pkg::CFG_KEY_B_REPORT: cfg_q.key_b_report <= cfg_wdata_i;
        tkc_pkg::CFG_KEY_C_CODE:   cfg_q.key_c_code   <= cfg_wdata_i;
        tkc_pkg::CFG_KEY_C_REPORT: cfg_q.key_c_report <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // flow control: input stage moves on when the result stage can take it
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_item_q.req_type      <= tkc_pkg::req_type_e'(s_axis_tuser);
      in_item_q.reg_address   <= s_axis_tdata[7:0];
      in_item_q.access_offset <= s_axis_tdata[15:8];
      in_item_q.write_data    <= s_axis_tdata[23:16];
      in_item_q.key_code      <= s_axis_tdata[31:24];
    end
  end

  tkc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (advance),
    .item_i   (in_item_q),
    .cfg_i    (cfg_q),
    .result_o (res_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_vld_q || m_axis_tready) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'b0, res_q.access_error, res_q.irq_pulse, res_q.read_data};

  // a result beat never flags both an interrupt and an access error
  a_irq_err_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[8] && m_axis_tdata[9]))
    else $error("irq and access error in one result beat");

  // read data is zero on flagged beats
  a_flag_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[8] || m_axis_tdata[9])) |->
      (m_axis_tdata[7:0] == 8'h00))
    else $error("flagged result beat carries read data");

  // input stalls only behind a held result with a full input stage
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_vld_q && out_vld_q && !m_axis_tready))
    else $error("input stalled without a blocked result");

  // a beat in the input stage reaches the result stage next cycle when drained
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_vld_q)
    else $error("advanced beat lost");

endmodule : touchkey_controller_regs_unit
`default_nettype wire

FILE: src/tkc_key_match.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tkc_key_match
// Looks a scan code up among the three configured keys (key a first) and
// forms the new status byte with bit 7 set for a press.
// ----------------------------------------------------------------------------
module tkc_key_match (
  input  wire logic [7:0]         key_code_i,
  input  wire tkc_pkg::cfg_t      cfg_i,
  output tkc_pkg::key_match_t     match_o
);

  logic [tkc_pkg::KEY_W-1:0] code;
  logic                      press;

  // strip the release bit
  assign code  = key_code_i[tkc_pkg::KEY_W-1:0];
  assign press = ~key_code_i[7];

  // priority lookup
  always_comb begin
    match_o.hit    = 1'b1;
    match_o.status = 8'h00;
    if (code == cfg_i.key_a_code) begin
      match_o.status = {press, cfg_i.key_a_report};
    end else if (code == cfg_i.key_b_code) begin
      match_o.status = {press, cfg_i.key_b_report};
    end else if (code == cfg_i.key_c_code) begin
      match_o.status = {press, cfg_i.key_c_report};
    end else begin
      match_o.hit = 1'b0;
    end
  end

endmodule : tkc_key_match
`default_nettype wire

FILE: src/tkc_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tkc_core
// Register decode, status register and firmware-download sequencer. The
// state advances on each beat that moves into the result register.
// ----------------------------------------------------------------------------
module tkc_core (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            fire_i,
  input  wire tkc_pkg::item_t  item_i,
  input  wire tkc_pkg::cfg_t   cfg_i,
  output tkc_pkg::result_t     result_o
);

  logic [7:0]                     key_status_q, key_status_d;
  logic [tkc_pkg::DL_STEP_W-1:0]  dl_step_q, dl_step_d;
  logic [7:0]                     dl_count_q, dl_count_d;
  tkc_pkg::key_match_t            match;
  logic [7:0]                     dl_ans;
  logic [tkc_pkg::DL_STEP_W-1:0]  dl_step_rd;
  logic [7:0]                     dl_count_rd;

  tkc_key_match u_key_match (
    .key_code_i (item_i.key_code),
    .cfg_i      (cfg_i),
    .match_o    (match)
  );

  // answer of a download read and the step it leaves behind
  always_comb begin
    dl_step_rd  = dl_step_q + 4'd1;
    dl_count_rd = dl_count_q;
    unique case (dl_step_q) inside
      tkc_pkg::DL_HELLO: dl_ans = tkc_pkg::DL_ANS_HELLO;
      tkc_pkg::DL_ACK1:  dl_ans = tkc_pkg::DL_ANS_ACK;
      tkc_pkg::DL_ERASE: dl_ans = tkc_pkg::DL_ANS_ERASE;
      tkc_pkg::DL_CNT1:  dl_ans = tkc_pkg::DL_ANS_CNT;
      tkc_pkg::DL_ACK2:  dl_ans = tkc_pkg::DL_ANS_ACK;
      tkc_pkg::DL_IMAGE: dl_ans = tkc_pkg::DL_ANS_IMAGE;
      tkc_pkg::DL_CNT2:  dl_ans = tkc_pkg::DL_ANS_CNT;
      tkc_pkg::DL_CHECK1, tkc_pkg::DL_CHECK2: begin
        dl_ans = tkc_pkg::DL_ANS_BUSY;
        // hold the step while the count runs down
        if (dl_count_q != 8'h00) begin
          dl_count_rd = dl_count_q - 8'd1;
          dl_step_rd  = dl_step_q;
        end
      end
      default: begin
        dl_ans     = tkc_pkg::DL_ANS_DONE;
        dl_step_rd = tkc_pkg::DL_HELLO;
      end
    endcase
  end

  // request decode
  always_comb begin
    result_o     = '0;
    key_status_d = key_status_q;
    dl_step_d    = dl_step_q;
    dl_count_d   = dl_count_q;
    unique case (item_i.req_type)
      tkc_pkg::REQ_READ: begin
        if (item_i.access_offset != 8'h00) begin
          result_o.access_error = 1'b1;
        end else begin
          unique case (item_i.reg_address)
            tkc_pkg::ADDR_STATUS: result_o.read_data = key_status_q;
            tkc_pkg::ADDR_HW_VER: result_o.read_data = tkc_pkg::HW_REV_BYTE;
            tkc_pkg::ADDR_FW_VER: result_o.read_data = tkc_pkg::FW_REV_BYTE;
            tkc_pkg::ADDR_MI_VER: result_o.read_data = tkc_pkg::MI_REV_BYTE;
            tkc_pkg::ADDR_DOWNLOAD: begin
              result_o.read_data = dl_ans;
              dl_step_d          = dl_step_rd;
              dl_count_d         = dl_count_rd;
            end
            default: result_o.access_error = 1'b1;
          endcase
        end
      end
      tkc_pkg::REQ_WRITE: begin
        if (item_i.access_offset != 8'h00) begin
          result_o.access_error = 1'b1;
        end else begin
          unique case (item_i.reg_address) inside
            tkc_pkg::ADDR_LED_ONOFF, tkc_pkg::ADDR_LED_DIM: ;
            tkc_pkg::ADDR_DOWNLOAD: begin
              // byte count is taken only at the two count steps
              if (dl_step_q == tkc_pkg::DL_CNT1 || dl_step_q == tkc_pkg::DL_CNT2) begin
                dl_count_d = item_i.write_data;
              end
            end
            default: result_o.access_error = 1'b1;
          endcase
        end
      end
      tkc_pkg::REQ_KEY: begin
        if (match.hit) begin
          key_status_d       = match.status;
          result_o.irq_pulse = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_status_q <= '0;
      dl_step_q    <= tkc_pkg::DL_HELLO;
      dl_count_q   <= '0;
    end else if (fire_i) begin
      key_status_q <= key_status_d;
      dl_step_q    <= dl_step_d;
      dl_count_q   <= dl_count_d;
    end
  end

endmodule : tkc_core
`default_nettype wire

FILE: verif/touchkey_controller_regs_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touchkey_controller_regs_unit_tb
// Self-checking bench for the touch-key register unit. A directed table runs
// first: reset values, version bytes, error cases, key hits and misses, the
// start of a download handshake. Random phases follow, each with its own key
// setting. They mix download traffic that tracks the handshake, key events
// aimed at the configured codes, plain accesses and noise. Every result beat
// is checked in order against a cycle-free model of the register unit.
// ----------------------------------------------------------------------------
module touchkey_controller_regs_unit_tb;
  import tkc_pkg::*;

  localparam int unsigned NUM_KEY_REGS   = 6;
  localparam int unsigned NUM_PHASES     = 6;
  localparam int unsigned PHASE_REQUESTS = 180;
  localparam int unsigned DRAIN_CYCLES   = 4;
  localparam int unsigned WATCHDOG_LIMIT = 5000;

  localparam result_t R_ZERO = '{8'h00, 1'b0, 1'b0};
  localparam result_t R_ERR  = '{8'h00, 1'b0, 1'b1};
  localparam result_t R_IRQ  = '{8'h00, 1'b1, 1'b0};

  typedef struct packed {
    item_t   req;
    logic    typed;
    result_t reply;
  } row_t;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // block ports
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = '0;
  logic [KEY_W-1:0]     cfg_wdata_i   = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // [7:0] reg_address, [15:8] access_offset, [23:16] write_data,
  // [31:24] key_code
  logic [31:0]          s_axis_tdata  = '0;
  // [1:0] req_type
  logic [1:0]           s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // [7:0] read_data, [8] irq_pulse, [9] access_error, [15:10] zero
  logic [15:0]          m_axis_tdata;

  touchkey_controller_regs_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // model state of the register unit
  logic [KEY_W-1:0]     key_regs [NUM_KEY_REGS];
  logic [7:0]           tk_status = '0;
  logic [DL_STEP_W-1:0] dl_step   = '0;
  logic [7:0]           dl_count  = '0;

  result_t pending_replies [$];
  bit      failed   = 1'b0;
  bit      no_gaps  = 1'b0;
  int      idle_run = 0;
  result_t want, seen;

  // directed table: typed replies where they are obvious, model otherwise
  row_t directed_rows [25] = '{
    '{'{REQ_READ,  ADDR_STATUS,    8'h00, 8'h00, 8'h00}, 1'b1, R_ZERO},
    '{'{REQ_READ,  ADDR_HW_VER,    8'h00, 8'h00, 8'h00}, 1'b1, '{8'h09, 1'b0, 1'b0}},
    '{'{REQ_READ,  ADDR_FW_VER,    8'h00, 8'h00, 8'h00}, 1'b1, '{8'h09, 1'b0, 1'b0}},
    '{'{REQ_READ,  ADDR_MI_VER,    8'h00, 8'h00, 8'h00}, 1'b1, R_ZERO},
    '{'{REQ_READ,  ADDR_STATUS,    8'hFF, 8'h00, 8'h00}, 1'b1, R_ERR},
    '{'{REQ_WRITE, ADDR_LED_ONOFF, 8'h00, 8'hFF, 8'h00}, 1'b1, R_ZERO},
    '{'{REQ_WRITE, ADDR_LED_DIM,   8'h00, 8'h00, 8'h00}, 1'b1, R_ZERO},
    '{'{REQ_WRITE, 8'hFF,          8'h00, 8'hA5, 8'h00}, 1'b1, R_ERR},
    '{'{REQ_READ,  8'h00,          8'h00, 8'h00, 8'h00}, 1'b1, R_ERR},
    '{'{REQ_WRITE, ADDR_DOWNLOAD,  8'h80, 8'h55, 8'h00}, 1'b1, R_ERR},
    '{'{REQ_KEY,   8'h00,          8'h00, 8'h00, 8'h10}, 1'b1, R_IRQ},
    '{'{REQ_READ,  ADDR_STATUS,    8'h00, 8'h00, 8'h00}, 1'b1, '{8'hE1, 1'b0, 1'b0}},
    '{'{REQ_KEY,   8'h00,          8'h00, 8'h00, 8'h91}, 1'b1, R_IRQ},
    '{'{REQ_READ,  ADDR_STATUS,    8'h00, 8'h00, 8'h00}, 1'b1, '{8'h62, 1'b0, 1'b0}},
    '{'{REQ_KEY,   8'hFF,          8'hFF, 8'hFF, 8'h92}, 1'b0, R_ZERO},
    '{'{REQ_KEY,   8'h00,          8'h00, 8'h00, 8'hFF}, 1'b1, R_ZERO},
    '{'{REQ_KEY,   8'h00,          8'h00, 8'h00, 8'h00}, 1'b1, R_ZERO},
    '{'{REQ_NOP,   8'hFF,          8'hFF, 8'hFF, 8'hFF}, 1'b1, R_ZERO},
    '{'{REQ_READ,  ADDR_DOWNLOAD,  8'h00, 8'h00, 8'h00}, 1'b1, '{8'h55, 1'b0, 1'b0}},
    '{'{REQ_READ,  ADDR_DOWNLOAD,  8'h00, 8'h00, 8'h00}, 1'b1, '{8'h8F, 1'b0, 1'b0}},
    '{'{REQ_READ,  ADDR_DOWNLOAD,  8'h00, 8'h00, 8'h00}, 1'b1, '{8'h82, 1'b0, 1'b0}},
    '{'{REQ_WRITE, ADDR_DOWNLOAD,  8'h00, 8'h01, 8'h00}, 1'b1, R_ZERO},
    '{'{REQ_READ,  ADDR_DOWNLOAD,  8'h00, 8'h00, 8'h00}, 1'b1, '{8'h84, 1'b0, 1'b0}},
    '{'{REQ_READ,  ADDR_DOWNLOAD,  8'h00, 8'h00, 8'h00}, 1'b0, R_ZERO},
    '{'{REQ_READ,  ADDR_DOWNLOAD,  8'h00, 8'h00, 8'h00}, 1'b0, R_ZERO}
  };

  // next answer of the download handshake, advances the step
  function automatic logic [7:0] download_reply();
    logic [DL_STEP_W-1:0] cur;
    logic [7:0]           ans;
    cur     = dl_step;
    dl_step = cur + 1'b1;
    case (cur)
      DL_HELLO:           ans = DL_ANS_HELLO;
      DL_ACK1, DL_ACK2:   ans = DL_ANS_ACK;
      DL_ERASE:           ans = DL_ANS_ERASE;
      DL_CNT1, DL_CNT2:   ans = DL_ANS_CNT;
      DL_IMAGE:           ans = DL_ANS_IMAGE;
      DL_CHECK1, DL_CHECK2: begin
        // hold the step while the count runs down
        if (dl_count != 8'h00) begin
          dl_count = dl_count - 1'b1;
          dl_step  = cur;
        end
        ans = DL_ANS_BUSY;
      end
      default: begin
        dl_step = DL_HELLO;
        ans     = DL_ANS_DONE;
      end
    endcase
    return ans;
  endfunction

  // reply of the register unit to one request, updates the model state
  function automatic result_t regs_response(input item_t req);
    result_t          r;
    logic [KEY_W-1:0] code;
    logic [KEY_W-1:0] rep;
    logic             hit;
    r = R_ZERO;
    case (req.req_type)
      REQ_READ: begin
        if (req.access_offset != 8'h00) begin
          r.access_error = 1'b1;
        end else begin
          case (req.reg_address)
            ADDR_STATUS:   r.read_data = tk_status;
            ADDR_HW_VER:   r.read_data = HW_REV_BYTE;
            ADDR_FW_VER:   r.read_data = FW_REV_BYTE;
            ADDR_MI_VER:   r.read_data = MI_REV_BYTE;
            ADDR_DOWNLOAD: r.read_data = download_reply();
            default:       r.access_error = 1'b1;
          endcase
        end
      end
      REQ_WRITE: begin
        if (req.access_offset != 8'h00) begin
          r.access_error = 1'b1;
        end else begin
          case (req.reg_address)
            ADDR_LED_ONOFF, ADDR_LED_DIM: ;
            ADDR_DOWNLOAD: begin
              if (dl_step == DL_CNT1 || dl_step == DL_CNT2) dl_count = req.write_data;
            end
            default: r.access_error = 1'b1;
          endcase
        end
      end
      REQ_KEY: begin
        // release bit dropped, key a wins over b, b over c
        code = req.key_code[KEY_W-1:0];
        hit  = 1'b1;
        rep  = '0;
        if (code == key_regs[CFG_KEY_A_CODE]) rep = key_regs[CFG_KEY_A_REPORT];
        else if (code == key_regs[CFG_KEY_B_CODE]) rep = key_regs[CFG_KEY_B_REPORT];
        else if (code == key_regs[CFG_KEY_C_CODE]) rep = key_regs[CFG_KEY_C_REPORT];
        else hit = 1'b0;
        if (hit) begin
          tk_status   = {~req.key_code[7], rep};
          r.irq_pulse = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // random request, download traffic follows the modeled handshake step
  function automatic item_t random_request();
    item_t       req;
    int unsigned pick;
    req.req_type      = REQ_NOP;
    req.reg_address   = 8'($urandom_range(0, 255));
    req.access_offset = 8'($urandom_range(0, 255));
    req.write_data    = 8'($urandom_range(0, 255));
    req.key_code      = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      // download session
      req.reg_address   = ADDR_DOWNLOAD;
      req.access_offset = 8'h00;
      if ((dl_step == DL_CNT1 || dl_step == DL_CNT2) && $urandom_range(0, 1) == 1) begin
        req.req_type   = REQ_WRITE;
        req.write_data = ($urandom_range(0, 29) == 0) ? 8'($urandom_range(0, 255))
                                                     : 8'($urandom_range(0, 5));
      end else if ($urandom_range(0, 9) == 0) begin
        req.req_type = REQ_WRITE;
      end else begin
        req.req_type = REQ_READ;
      end
    end else if (pick < 65) begin
      // key events, mostly on configured codes
      req.req_type = REQ_KEY;
      case ($urandom_range(0, 3))
        0: req.key_code[KEY_W-1:0] = key_regs[CFG_KEY_A_CODE];
        1: req.key_code[KEY_W-1:0] = key_regs[CFG_KEY_B_CODE];
        2: req.key_code[KEY_W-1:0] = key_regs[CFG_KEY_C_CODE];
        default: ;
      endcase
    end else if (pick < 80) begin
      // well-formed accesses
      req.access_offset = 8'h00;
      req.req_type      = REQ_READ;
      case ($urandom_range(0, 5))
        0: req.reg_address = ADDR_STATUS;
        1: req.reg_address = ADDR_HW_VER;
        2: req.reg_address = ADDR_FW_VER;
        3: req.reg_address = ADDR_MI_VER;
        4: begin
          req.req_type    = REQ_WRITE;
          req.reg_address = ADDR_LED_ONOFF;
        end
        default: begin
          req.req_type    = REQ_WRITE;
          req.reg_address = ADDR_LED_DIM;
        end
      endcase
    end else if (pick < 90) begin
      // bad offset or bad address
      req.req_type = ($urandom_range(0, 1) == 1) ? REQ_WRITE : REQ_READ;
      if ($urandom_range(0, 1) == 1) req.access_offset = 8'($urandom_range(1, 255));
      else req.access_offset = 8'h00;
    end else if (pick >= 95) begin
      req.req_type = req_type_e'($urandom_range(0, 3));
    end
    return req;
  endfunction

  // send one request beat, queue its reply once accepted
  task automatic issue_request(input item_t req, input logic typed, input result_t reply);
    result_t r;
    if (!no_gaps) begin
      while ($urandom_range(0, 99) < 33) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {req.key_code, req.write_data, req.access_offset, req.reg_address};
    s_axis_tuser  <= req.req_type;
    do @(posedge clk_i); while (!s_axis_tready);
    r = regs_response(req);
    pending_replies.push_back(typed ? reply : r);
  endtask

  // hold off until every queued reply has come back
  task automatic wait_drained();
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // result side: random stalls, in-order compare, watchdog
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_run = 0;
    else idle_run = idle_run + 1;
    if (m_axis_tvalid && m_axis_tready) begin
      seen.read_data    = m_axis_tdata[7:0];
      seen.irq_pulse    = m_axis_tdata[8];
      seen.access_error = m_axis_tdata[9];
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %h", $time, m_axis_tdata);
        failed = 1'b1;
      end else begin
        want = pending_replies.pop_front();
        if (seen.read_data !== want.read_data) begin
          $display("%0t: read_data expected %h actual %h", $time, want.read_data,
                   seen.read_data);
          failed = 1'b1;
        end
        if (seen.irq_pulse !== want.irq_pulse) begin
          $display("%0t: irq_pulse expected %b actual %b", $time, want.irq_pulse,
                   seen.irq_pulse);
          failed = 1'b1;
        end
        if (seen.access_error !== want.access_error) begin
          $display("%0t: access_error expected %b actual %b", $time, want.access_error,
                   seen.access_error);
          failed = 1'b1;
        end
      end
    end
    m_axis_tready <= no_gaps ? 1'b1 : ($urandom_range(0, 99) >= 33);
    if (idle_run >= WATCHDOG_LIMIT) begin
      $display("touchkey_controller_regs_unit: mismatch");
      $finish;
    end
  end

  // stimulus
  initial begin
    logic [KEY_W-1:0] setting [NUM_KEY_REGS];
    key_regs[CFG_KEY_A_CODE]   = CFG_RESET.key_a_code;
    key_regs[CFG_KEY_A_REPORT] = CFG_RESET.key_a_report;
    key_regs[CFG_KEY_B_CODE]   = CFG_RESET.key_b_code;
    key_regs[CFG_KEY_B_REPORT] = CFG_RESET.key_b_report;
    key_regs[CFG_KEY_C_CODE]   = CFG_RESET.key_c_code;
    key_regs[CFG_KEY_C_REPORT] = CFG_RESET.key_c_report;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table on reset keys
    foreach (directed_rows[r])
      issue_request(directed_rows[r].req, directed_rows[r].typed, directed_rows[r].reply);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      s_axis_tvalid <= 1'b0;
      wait_drained();
      // key setting of this phase, extremes first
      for (int i = 0; i < NUM_KEY_REGS; i++) begin
        case (ph)
          0: setting[i] = '0;
          1: setting[i] = '1;
          default: setting[i] = KEY_W'($urandom_range(0, 127));
        endcase
      end
      if (ph == 3) setting[CFG_KEY_B_CODE] = setting[CFG_KEY_A_CODE];
      if (ph == 4) setting[CFG_KEY_C_CODE] = setting[CFG_KEY_B_CODE];
      for (int i = 0; i < NUM_KEY_REGS; i++) begin
        cfg_we_i    <= 1'b1;
        cfg_idx_i   <= CFG_IDX_W'(i);
        cfg_wdata_i <= setting[i];
        @(posedge clk_i);
        key_regs[i] = setting[i];
      end
      cfg_we_i <= 1'b0;
      // one phase runs with both sides at full rate
      no_gaps = (ph == 2);
      for (int n = 0; n < PHASE_REQUESTS; n++) issue_request(random_request(), 1'b0, R_ZERO);
    end

    s_axis_tvalid <= 1'b0;
    wait_drained();
    if (!failed && pending_replies.size() == 0) begin
      $display("touchkey_controller_regs_unit: match");
    end else begin
      $display("touchkey_controller_regs_unit: mismatch");
    end
    $finish;
  end

endmodule
